// ===== rtl/core/bzf_pkg.sv =====
// ----------------------------------------------------------------------------
// bzf_pkg - shared definitions for the quadratic Bezier flattener
// Command codes, register indexes, fixed widths and controller/datapath links.
// ----------------------------------------------------------------------------
package bzf_pkg;

  // Outline commands
  localparam int FUNC_W = 2;
  localparam logic [FUNC_W-1:0] FUNC_MOVE  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_LINE  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CURVE = 2'd2;

  // Configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 24;
  localparam logic [CFG_INDEX_W-1:0] REG_SCALE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_STEPS = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_EMIT  = 2'd2;

  localparam int SCALE_W = 24;
  localparam int STEPS_W = 7;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd65536;
  localparam logic [STEPS_W-1:0] STEPS_RESET = 7'd4;
  localparam logic               EMIT_RESET  = 1'b1;

  // Q16.16 results
  localparam int SEG_W = 32;
  localparam logic [SEG_W-1:0] SEG_MAX = 32'h7FFF_FFFF;
  localparam logic [SEG_W-1:0] SEG_MIN = 32'h8000_0000;

  // Quotient bits retired per divider cycle
  localparam int DIV_BITS = 4;

  // Running maximum y after reset
  localparam int INIT_MAX_Y = -1000;
  localparam int MAX_Y_MIN_W = 11;

  typedef struct packed {
    logic item;     // input transfer this cycle
    logic init0;    // load S(0)
    logic init1;    // load first and second differences
    logic mul;      // scale S(k), step the difference engine
    logic load;     // load divider from product
    logic step;     // one divider iteration
    logic advance;  // current point becomes previous, k++
    logic out_seg;  // write chord to output register
    logic out_zero; // write measure-only result
  } bzf_cmd_t;

  typedef struct packed {
    logic div_done;
    logic first_point;
    logic last_chord;
    logic out_free;
  } bzf_status_t;

endpackage

// ===== rtl/core/bzf_lane.sv =====
// ----------------------------------------------------------------------------
// bzf_lane - one axis of the flattener datapath
// Forward-difference curve evaluator, scale multiplier and floor divider.
// ----------------------------------------------------------------------------
module bzf_lane #(
  parameter int COORD_WIDTH = 16,
  parameter int MAX_STEPS   = 64
) (
  input  logic                              clk,
  input  bzf_pkg::bzf_cmd_t                 cmd,
  input  logic signed [COORD_WIDTH-1:0]     p,
  input  logic signed [COORD_WIDTH-1:0]     c,
  input  logic signed [COORD_WIDTH-1:0]     e,
  input  logic [$clog2(MAX_STEPS+1)-1:0]    n,
  input  logic [$clog2(MAX_STEPS*MAX_STEPS+1)-1:0] nn,
  input  logic [bzf_pkg::SCALE_W-1:0]       scale,
  output logic [bzf_pkg::SEG_W-1:0]         prev,
  output logic [bzf_pkg::SEG_W-1:0]         res
);

  localparam int CW  = COORD_WIDTH;
  localparam int N2W = $clog2(MAX_STEPS * MAX_STEPS + 1);
  localparam int SW  = CW + N2W + 4;
  localparam int PW  = SW + bzf_pkg::SCALE_W;
  localparam int QW  = ((CW + 24 + bzf_pkg::DIV_BITS - 1) / bzf_pkg::DIV_BITS)
                       * bzf_pkg::DIV_BITS;

  logic signed [SW-1:0] s_acc, d_acc, dd_acc;
  logic signed [SW-1:0] p_w, c_w, e_w, bend, diff, s_init, d_init;
  logic signed [PW-1:0] prod, prod_next;
  logic [PW-2:0]        mag;
  logic                 sgn;
  logic [N2W-1:0]       rem, rem_next;
  logic [QW-1:0]        quo, quo_next;
  logic signed [QW:0]   v;
  logic [QW-bzf_pkg::SEG_W+1:0] upper;

  always_comb begin
    p_w    = SW'(p);
    c_w    = SW'(c);
    e_w    = SW'(e);
    bend   = p_w - (c_w <<< 1) + e_w;
    diff   = c_w - p_w;
    s_init = p_w * SW'($signed({1'b0, nn}));
    d_init = ((diff * SW'($signed({1'b0, n}))) <<< 1) + bend;
    prod_next = PW'(s_acc) * PW'($signed({1'b0, scale}));
    // floor for negatives: divide the ones' complement, complement the quotient
    mag = prod[PW-2:0] ^ {(PW-1){prod[PW-1]}};
  end

  // Restoring division, DIV_BITS quotient bits per cycle
  always_comb begin
    logic [N2W:0] t;
    rem_next = rem;
    quo_next = quo;
    for (int i = 0; i < bzf_pkg::DIV_BITS; i++) begin
      t        = {rem_next, quo_next[QW-1]};
      quo_next = {quo_next[QW-2:0], 1'b0};
      if (t >= {1'b0, nn}) begin
        t           = t - {1'b0, nn};
        quo_next[0] = 1'b1;
      end
      rem_next = t[N2W-1:0];
    end
  end

  always_comb begin
    v     = $signed({1'b0, quo} ^ {(QW+1){sgn}});
    upper = v[QW:bzf_pkg::SEG_W-1];
    if ((&upper) || !(|upper)) begin
      res = v[bzf_pkg::SEG_W-1:0];
    end else if (v[QW]) begin
      res = bzf_pkg::SEG_MIN;
    end else begin
      res = bzf_pkg::SEG_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init0) begin
      s_acc <= s_init;
    end
    if (cmd.init1) begin
      d_acc  <= d_init;
      dd_acc <= bend <<< 1;
    end
    if (cmd.mul) begin
      prod  <= prod_next;
      s_acc <= s_acc + d_acc;
      d_acc <= d_acc + dd_acc;
    end
    if (cmd.load) begin
      sgn <= prod[PW-1];
      rem <= mag[QW+N2W-1:QW];
      quo <= mag[QW-1:0];
    end
    if (cmd.step) begin
      rem <= rem_next;
      quo <= quo_next;
    end
    if (cmd.advance) begin
      prev <= res;
    end
  end

endmodule

// ===== rtl/core/bzf_datapath.sv =====
// ----------------------------------------------------------------------------
// bzf_datapath - pen state, operand registers, two axis lanes, output register
// Carries out the controller's commands and reports sequencing status.
// ----------------------------------------------------------------------------
module bzf_datapath #(
  parameter int COORD_WIDTH = 16,
  parameter int MAX_STEPS   = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  bzf_pkg::bzf_cmd_t                 cmd,
  output bzf_pkg::bzf_status_t              status,
  input  logic [bzf_pkg::FUNC_W-1:0]        func,
  input  logic signed [COORD_WIDTH-1:0]     ctrl_x,
  input  logic signed [COORD_WIDTH-1:0]     ctrl_y,
  input  logic signed [COORD_WIDTH-1:0]     end_x,
  input  logic signed [COORD_WIDTH-1:0]     end_y,
  input  logic [bzf_pkg::SCALE_W-1:0]       scale_factor,
  input  logic [bzf_pkg::STEPS_W-1:0]       steps_per_curve,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic signed [bzf_pkg::SEG_W-1:0]  seg_x0,
  output logic signed [bzf_pkg::SEG_W-1:0]  seg_y0,
  output logic signed [bzf_pkg::SEG_W-1:0]  seg_x1,
  output logic signed [bzf_pkg::SEG_W-1:0]  seg_y1,
  output logic                              last,
  output logic signed [COORD_WIDTH-1:0]     top_y
);

  localparam int CW  = COORD_WIDTH;
  localparam int NW  = $clog2(MAX_STEPS + 1);
  localparam int N2W = $clog2(MAX_STEPS * MAX_STEPS + 1);
  localparam int MW  = (CW > bzf_pkg::MAX_Y_MIN_W) ? CW : bzf_pkg::MAX_Y_MIN_W;
  localparam int QW  = ((CW + 24 + bzf_pkg::DIV_BITS - 1) / bzf_pkg::DIV_BITS)
                       * bzf_pkg::DIV_BITS;
  localparam int DIV_STEPS = QW / bzf_pkg::DIV_BITS;
  localparam int DCW = $clog2(DIV_STEPS);

  logic signed [CW-1:0] pen_x, pen_y;
  logic signed [CW-1:0] px, py, cx, cy, ex, ey;
  logic signed [MW-1:0] max_y;
  logic [NW-1:0]        n, k, n_sel;
  logic [N2W-1:0]       nn;
  logic [DCW-1:0]       dcnt;
  logic [31:0]          spc_wide, n_wide;
  logic                 draw, moves;
  logic [bzf_pkg::SEG_W-1:0] x_prev, x_res, y_prev, y_res;

  assign draw  = (func == bzf_pkg::FUNC_LINE) || (func == bzf_pkg::FUNC_CURVE);
  assign moves = draw || (func == bzf_pkg::FUNC_MOVE);

  // Chord count: a line is one chord, curve steps clamped to 1..MAX_STEPS
  always_comb begin
    spc_wide = 32'(steps_per_curve);
    if (func == bzf_pkg::FUNC_LINE || spc_wide == 32'd0) begin
      n_wide = 32'd1;
    end else if (spc_wide > 32'(MAX_STEPS)) begin
      n_wide = 32'(MAX_STEPS);
    end else begin
      n_wide = spc_wide;
    end
    n_sel = n_wide[NW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pen_x     <= '0;
      pen_y     <= '0;
      max_y     <= MW'(bzf_pkg::INIT_MAX_Y);
      k         <= '0;
      dcnt      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.item && moves) begin
        pen_x <= end_x;
        pen_y <= end_y;
      end
      if (cmd.item && draw && (MW'(end_y) > max_y)) begin
        max_y <= MW'(end_y);
      end
      if (cmd.item) begin
        k <= '0;
      end else if (cmd.advance) begin
        k <= k + 1'b1;
      end
      if (cmd.load) begin
        dcnt <= '0;
      end else if (cmd.step) begin
        dcnt <= dcnt + 1'b1;
      end
      if (cmd.out_seg || cmd.out_zero) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.item) begin
      px <= pen_x;
      py <= pen_y;
      cx <= ctrl_x;
      cy <= ctrl_y;
      ex <= end_x;
      ey <= end_y;
      n  <= n_sel;
      nn <= N2W'(n_sel) * N2W'(n_sel);
    end
    if (cmd.out_seg) begin
      seg_x0 <= x_prev;
      seg_y0 <= y_prev;
      seg_x1 <= x_res;
      seg_y1 <= y_res;
      last   <= (k == n);
      top_y  <= max_y[CW-1:0];
    end else if (cmd.out_zero) begin
      seg_x0 <= '0;
      seg_y0 <= '0;
      seg_x1 <= '0;
      seg_y1 <= '0;
      last   <= 1'b1;
      top_y  <= max_y[CW-1:0];
    end
  end

  bzf_lane #(.COORD_WIDTH(COORD_WIDTH), .MAX_STEPS(MAX_STEPS)) u_lane_x (
    .clk(clk), .cmd(cmd), .p(px), .c(cx), .e(ex), .n(n), .nn(nn),
    .scale(scale_factor), .prev(x_prev), .res(x_res)
  );

  bzf_lane #(.COORD_WIDTH(COORD_WIDTH), .MAX_STEPS(MAX_STEPS)) u_lane_y (
    .clk(clk), .cmd(cmd), .p(py), .c(cy), .e(ey), .n(n), .nn(nn),
    .scale(scale_factor), .prev(y_prev), .res(y_res)
  );

  always_comb begin
    status.div_done    = (dcnt == DCW'(DIV_STEPS - 1));
    status.first_point = (k == '0);
    status.last_chord  = (k == n);
    status.out_free    = !out_valid || out_ready;
  end

endmodule

// ===== rtl/core/bzf_ctrl.sv =====
// ----------------------------------------------------------------------------
// bzf_ctrl - sequencer for the Bezier flattener
// Walks each command through setup, per-point scale/divide and chord output.
// ----------------------------------------------------------------------------
module bzf_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic [bzf_pkg::FUNC_W-1:0] func,
  input  logic                       emit_segments,
  input  bzf_pkg::bzf_status_t       status,
  output logic                       in_ready,
  output bzf_pkg::bzf_cmd_t          cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_INIT0 = 3'd1;
  localparam logic [2:0] ST_INIT1 = 3'd2;
  localparam logic [2:0] ST_MUL   = 3'd3;
  localparam logic [2:0] ST_LOAD  = 3'd4;
  localparam logic [2:0] ST_DIV   = 3'd5;
  localparam logic [2:0] ST_EMIT  = 3'd6;
  localparam logic [2:0] ST_MEAS  = 3'd7;

  logic [2:0] state, state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    in_ready   = (state == ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.item = 1'b1;
          if (func == bzf_pkg::FUNC_LINE || func == bzf_pkg::FUNC_CURVE) begin
            state_next = emit_segments ? ST_INIT0 : ST_MEAS;
          end
        end
      end
      ST_INIT0: begin
        cmd.init0  = 1'b1;
        state_next = ST_INIT1;
      end
      ST_INIT1: begin
        cmd.init1  = 1'b1;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_LOAD;
      end
      ST_LOAD: begin
        cmd.load   = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.step = 1'b1;
        if (status.div_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // the pen point only seeds the first chord
        if (status.first_point) begin
          cmd.advance = 1'b1;
          state_next  = ST_MUL;
        end else if (status.out_free) begin
          cmd.out_seg = 1'b1;
          cmd.advance = 1'b1;
          state_next  = status.last_chord ? ST_IDLE : ST_MUL;
        end
      end
      ST_MEAS: begin
        if (status.out_free) begin
          cmd.out_zero = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/core/quadratic_bezier_flattener.sv =====
// ----------------------------------------------------------------------------
// quadratic_bezier_flattener - outline command to scaled chord converter
// Turns move/line/quadratic-curve commands into Q16.16 line segments.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (in_valid/in_ready): one command per transfer. A move sets
//   the pen and gives nothing; a line gives one segment; a curve gives
//   steps_per_curve chords (1..MAX_STEPS), the final one with last set.
//   Unknown command codes are dropped. In measure mode (emit_segments = 0) a
//   line or curve gives a single zero segment carrying only top_y.
//   Output channel (out_valid/out_ready): one registered result per transfer.
//   Config channel (cfg_valid/cfg_ready): always ready; write only when idle.
// Sequencing
//   Each curve point passes through the scale multiply, divider load, the
//   4-bit floor-division iterations and the chord write. The pen point is
//   run through the same path. The divider iterations set the rate. in_ready
//   rises once the last result sits in the output register, so the next
//   command is taken while that result still waits.
// Reset clears pen to zero, maximum y to -1000, config to 1.0 / 4 / emit.
// A stalled receiver holds the sequencer before the next chord write.
// ----------------------------------------------------------------------------
module quadratic_bezier_flattener #(
  parameter int COORD_WIDTH = 16,
  parameter int MAX_STEPS   = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  // command transfer
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [bzf_pkg::FUNC_W-1:0]          func,
  input  logic signed [COORD_WIDTH-1:0]       ctrl_x,
  input  logic signed [COORD_WIDTH-1:0]       ctrl_y,
  input  logic signed [COORD_WIDTH-1:0]       end_x,
  input  logic signed [COORD_WIDTH-1:0]       end_y,
  // result transfer
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [bzf_pkg::SEG_W-1:0]    seg_x0,
  output logic signed [bzf_pkg::SEG_W-1:0]    seg_y0,
  output logic signed [bzf_pkg::SEG_W-1:0]    seg_x1,
  output logic signed [bzf_pkg::SEG_W-1:0]    seg_y1,
  output logic                                last,
  output logic signed [COORD_WIDTH-1:0]       top_y,
  // register writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bzf_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [bzf_pkg::CFG_DATA_W-1:0]      cfg_data
);

  logic [bzf_pkg::SCALE_W-1:0] scale_factor;
  logic [bzf_pkg::STEPS_W-1:0] steps_per_curve;
  logic                        emit_segments;

  bzf_pkg::bzf_cmd_t    cmd;
  bzf_pkg::bzf_status_t status;

  // Register writes never stall
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_factor    <= bzf_pkg::SCALE_RESET;
      steps_per_curve <= bzf_pkg::STEPS_RESET;
      emit_segments   <= bzf_pkg::EMIT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        bzf_pkg::REG_SCALE: scale_factor    <= cfg_data[bzf_pkg::SCALE_W-1:0];
        bzf_pkg::REG_STEPS: steps_per_curve <= cfg_data[bzf_pkg::STEPS_W-1:0];
        bzf_pkg::REG_EMIT:  emit_segments   <= cfg_data[0];
        default: begin
          // index beyond the register list: transfer taken, nothing stored
        end
      endcase
    end
  end

  // Sequencer: owns the handshake on the command side
  bzf_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .func          (func),
    .emit_segments (emit_segments),
    .status        (status),
    .in_ready      (in_ready),
    .cmd           (cmd)
  );

  // Arithmetic, pen tracking and the output register
  bzf_datapath #(
    .COORD_WIDTH (COORD_WIDTH),
    .MAX_STEPS   (MAX_STEPS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .func            (func),
    .ctrl_x          (ctrl_x),
    .ctrl_y          (ctrl_y),
    .end_x           (end_x),
    .end_y           (end_y),
    .scale_factor    (scale_factor),
    .steps_per_curve (steps_per_curve),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .seg_x0          (seg_x0),
    .seg_y0          (seg_y0),
    .seg_x1          (seg_x1),
    .seg_y1          (seg_y1),
    .last            (last),
    .top_y           (top_y)
  );

`ifndef SYNTHESIS
  // Leaving reset: nothing pending, commands welcome
  a_reset_clean: assert property (@(posedge clk) rst |=> !out_valid && in_ready)
    else $error("output pending or input blocked after reset");

  // A chord that is not the last of its command means the command is unfinished
  a_busy_mid_command: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> !in_ready)
    else $error("new command taken before previous one finished");

  // A move never produces a result
  a_move_silent: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && func == bzf_pkg::FUNC_MOVE && !out_valid |=> !out_valid)
    else $error("move command produced a result");
`endif

endmodule

// ===== tb/sv/quadratic_bezier_flattener_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadratic_bezier_flattener_tb - self-checking bench for the outline flattener
// Drives move, line and curve commands under several register settings, with
// random sender gaps and receiver stalls. Expected chords are worked out at
// each command transfer and each result transfer is checked against the oldest.
// ----------------------------------------------------------------------------
module quadratic_bezier_flattener_tb;
  import bzf_pkg::*;

  localparam int COORD_W        = 16;
  localparam int STEP_LIMIT     = 64;
  // worst case is a few hundred items of 64 chords with long stalls
  localparam int TIMEOUT_CYCLES = 1_500_000;
  // covers a command still in flight
  localparam int SETTLE_CYCLES  = 40;
  localparam int RANDOM_PHASES  = 7;
  localparam int PHASE_ITEMS    = 27;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam logic signed [COORD_W-1:0] C_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic signed [COORD_W-1:0] C_MAX = {1'b0, {(COORD_W-1){1'b1}}};

  // receiver stall patterns
  typedef enum logic [1:0] {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

  typedef struct {
    logic signed [SEG_W-1:0]   x0, y0, x1, y1;
    logic                      last;
    logic signed [COORD_W-1:0] top;
  } chord_t;

  // --------------------------------------------------------------------------
  // Chord predictor and result store
  // --------------------------------------------------------------------------
  class chord_scoreboard;
    logic signed [COORD_W-1:0] pen_x, pen_y, peak_y;
    logic [SCALE_W-1:0]        scale;
    logic [STEPS_W-1:0]        steps;
    logic                      emit;
    chord_t                    chords_due[$];
    int                        mismatches;

    function new();
      pen_x      = '0;
      pen_y      = '0;
      peak_y     = COORD_W'(INIT_MAX_Y);
      scale      = SCALE_RESET;
      steps      = STEPS_RESET;
      emit       = EMIT_RESET;
      mismatches = 0;
    endfunction

    function void set_register(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
      case (index)
        REG_SCALE: scale = data[SCALE_W-1:0];
        REG_STEPS: steps = data[STEPS_W-1:0];
        REG_EMIT:  emit  = data[0];
        default: ;
      endcase
    endfunction

    // floor(num * scale / den) in Q16.16, clamped to the 32-bit signed range
    function logic signed [SEG_W-1:0] to_q16(longint num, longint den);
      longint scl, prod, quo;
      scl  = scale;
      prod = num * scl;
      quo  = prod / den;
      if (prod % den != 0 && prod < 0) quo = quo - 1;
      if (quo > longint'($signed(SEG_MAX))) quo = longint'($signed(SEG_MAX));
      if (quo < longint'($signed(SEG_MIN))) quo = longint'($signed(SEG_MIN));
      return quo[SEG_W-1:0];
    endfunction

    function void add_chord(logic signed [SEG_W-1:0] x0, logic signed [SEG_W-1:0] y0,
                            logic signed [SEG_W-1:0] x1, logic signed [SEG_W-1:0] y1,
                            logic last);
      chord_t c;
      c.x0   = x0;
      c.y0   = y0;
      c.x1   = x1;
      c.y1   = y1;
      c.last = last;
      c.top  = peak_y;
      chords_due.push_back(c);
    endfunction

    function void note_command(logic [FUNC_W-1:0] func,
                               logic signed [COORD_W-1:0] cx, logic signed [COORD_W-1:0] cy,
                               logic signed [COORD_W-1:0] ex, logic signed [COORD_W-1:0] ey);
      longint px, py, qx, qy, tx, ty, n, n2, k, a, b, c;
      logic signed [SEG_W-1:0] ox, oy, nx, ny;
      px = pen_x;
      py = pen_y;
      qx = cx;
      qy = cy;
      tx = ex;
      ty = ey;
      case (func)
        FUNC_MOVE: begin
          pen_x = ex;
          pen_y = ey;
        end
        FUNC_LINE, FUNC_CURVE: begin
          pen_x = ex;
          pen_y = ey;
          if (ey > peak_y) peak_y = ey;
          if (!emit) begin
            add_chord('0, '0, '0, '0, 1'b1);
          end else if (func == FUNC_LINE) begin
            add_chord(to_q16(px, 1), to_q16(py, 1), to_q16(tx, 1), to_q16(ty, 1), 1'b1);
          end else begin
            n  = (steps == 0) ? 1 : ((steps > STEP_LIMIT) ? STEP_LIMIT : steps);
            n2 = n * n;
            ox = to_q16(px, 1);
            oy = to_q16(py, 1);
            for (k = 1; k <= n; k++) begin
              // Bernstein weights scaled by n squared
              a  = (n - k) * (n - k);
              b  = 2 * k * (n - k);
              c  = k * k;
              nx = to_q16(a * px + b * qx + c * tx, n2);
              ny = to_q16(a * py + b * qy + c * ty, n2);
              add_chord(ox, oy, nx, ny, k == n);
              ox = nx;
              oy = ny;
            end
          end
        end
        default: ;
      endcase
    endfunction

    function int pending();
      return chords_due.size();
    endfunction

    task flag_mismatch(string msg);
      $display("%0t: %s", $time, msg);
      mismatches++;
    endtask

    task compare_field(string name, logic signed [SEG_W-1:0] got,
                       logic signed [SEG_W-1:0] want);
      if (got !== want)
        flag_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
    endtask

    task check_chord(logic signed [SEG_W-1:0] x0, logic signed [SEG_W-1:0] y0,
                     logic signed [SEG_W-1:0] x1, logic signed [SEG_W-1:0] y1,
                     logic last, logic signed [COORD_W-1:0] top);
      chord_t c;
      if (chords_due.size() == 0) begin
        flag_mismatch("result transfer with no chord expected");
        return;
      end
      c = chords_due.pop_front();
      compare_field("seg_x0", x0, c.x0);
      compare_field("seg_y0", y0, c.y0);
      compare_field("seg_x1", x1, c.x1);
      compare_field("seg_y1", y1, c.y1);
      compare_field("last", SEG_W'(last), SEG_W'(c.last));
      compare_field("top_y", SEG_W'(top), SEG_W'(c.top));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Signals; every input starts at a known value
  // --------------------------------------------------------------------------
  logic                      clk;
  logic                      rst       = 1'b1;
  logic                      in_valid  = 1'b0;
  logic                      in_ready;
  logic [FUNC_W-1:0]         func      = FUNC_MOVE;
  logic signed [COORD_W-1:0] ctrl_x    = '0;
  logic signed [COORD_W-1:0] ctrl_y    = '0;
  logic signed [COORD_W-1:0] end_x     = '0;
  logic signed [COORD_W-1:0] end_y     = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic signed [SEG_W-1:0]   seg_x0, seg_y0, seg_x1, seg_y1;
  logic                      last;
  logic signed [COORD_W-1:0] top_y;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_W-1:0]    cfg_index = REG_SCALE;
  logic [CFG_DATA_W-1:0]     cfg_data  = '0;

  chord_scoreboard sb = new();
  int              cycle_count = 0;
  rx_mode_t        rx_mode     = RX_OPEN;
  int              rx_left     = 0;
  int              rx_tick     = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  quadratic_bezier_flattener #(
    .COORD_WIDTH (COORD_W),
    .MAX_STEPS   (STEP_LIMIT)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .func      (func),
    .ctrl_x    (ctrl_x),
    .ctrl_y    (ctrl_y),
    .end_x     (end_x),
    .end_y     (end_y),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .seg_x0    (seg_x0),
    .seg_y0    (seg_y0),
    .seg_x1    (seg_x1),
    .seg_y1    (seg_y1),
    .last      (last),
    .top_y     (top_y),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Watchdog: a hung handshake ends the run as a failure
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == TIMEOUT_CYCLES) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Result side: check each transfer, then pick out_ready for the next edge.
  // The stall pattern is redrawn at random intervals from open, light random,
  // heavy random and a one-in-four periodic ready.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_chord(seg_x0, seg_y0, seg_x1, seg_y1, last, top_y);
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_left <= $urandom_range(64, 300);
    end else begin
      rx_left <= rx_left - 1;
    end
    rx_tick <= rx_tick + 1;
    case (rx_mode)
      RX_OPEN:     out_ready <= 1'b1;
      RX_LIGHT:    out_ready <= ($urandom_range(0, 99) >= 30);
      RX_HEAVY:    out_ready <= ($urandom_range(0, 99) >= 85);
      RX_PERIODIC: out_ready <= (rx_tick % 4 == 0);
      default:     out_ready <= 1'b1;
    endcase
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // One command transfer. Valid is left high so a following command goes out
  // back to back; a gap is made by pause_input.
  task send_command(logic [FUNC_W-1:0] f, logic signed [COORD_W-1:0] cx,
                    logic signed [COORD_W-1:0] cy, logic signed [COORD_W-1:0] ex,
                    logic signed [COORD_W-1:0] ey);
    in_valid <= 1'b1;
    func     <= f;
    ctrl_x   <= cx;
    ctrl_y   <= cy;
    end_x    <= ex;
    end_y    <= ey;
    do @(posedge clk); while (!in_ready);
    sb.note_command(f, cx, cy, ex, ey);
  endtask

  task pause_input(int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Wait until every chord is in, then let a command with no result settle
  task drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes all three registers back to back; only call when the block is idle
  task configure(logic [CFG_DATA_W-1:0] scale_data, logic [CFG_DATA_W-1:0] steps_data,
                 logic [CFG_DATA_W-1:0] emit_data);
    logic [CFG_INDEX_W-1:0] idx [3];
    logic [CFG_DATA_W-1:0]  val [3];
    idx = '{REG_SCALE, REG_STEPS, REG_EMIT};
    val = '{scale_data, steps_data, emit_data};
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      do @(posedge clk); while (!cfg_ready);
      sb.set_register(idx[i], val[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  // Mix of corner values, small values (floor rounding) and full-range values
  function logic signed [COORD_W-1:0] pick_coord();
    int v;
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 4))
          0:       return C_MIN;
          1:       return C_MAX;
          2:       return COORD_W'(-1);
          3:       return '0;
          default: return COORD_W'(1);
        endcase
      end
      1, 2: begin
        v = $urandom_range(0, 32);
        return COORD_W'(v - 16);
      end
      default: return COORD_W'($urandom);
    endcase
  endfunction

  function logic [FUNC_W-1:0] pick_func();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return FUNC_MOVE;
    if (r < 50) return FUNC_LINE;
    if (r < 95) return FUNC_CURVE;
    return FUNC_UNUSED;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    int                    burst_left;
    int                    steps_val;
    logic [CFG_DATA_W-1:0] scale_w, steps_w, emit_w;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: unit scale, four chords, segments on.
    // First line ends below the initial maximum, so top_y stays at -1000.
    send_command(FUNC_LINE, pick_coord(), pick_coord(), C_MAX, C_MIN);
    send_command(FUNC_CURVE, C_MIN, C_MAX, C_MIN, C_MIN);
    send_command(FUNC_UNUSED, pick_coord(), pick_coord(), pick_coord(), pick_coord());
    send_command(FUNC_MOVE, pick_coord(), pick_coord(), 16'sd100, -16'sd200);
    send_command(FUNC_CURVE, -16'sd7, 16'sd3, 16'sd5, -16'sd9);
    send_command(FUNC_LINE, pick_coord(), pick_coord(), -16'sd1, -16'sd1);
    send_command(FUNC_LINE, pick_coord(), pick_coord(), C_MIN, C_MAX);
    // degenerate curve: pen, control and end all equal
    send_command(FUNC_CURVE, C_MIN, C_MAX, C_MIN, C_MAX);

    // Largest scale and step count: coordinates far from zero saturate
    drain();
    configure('1, 24'(STEP_LIMIT), 24'd1);
    send_command(FUNC_CURVE, C_MAX, C_MIN, C_MIN, C_MAX);
    send_command(FUNC_LINE, pick_coord(), pick_coord(), C_MIN, C_MIN);

    // Zero scale; zero steps behaves as one
    drain();
    configure('0, 24'd0, 24'd1);
    send_command(FUNC_CURVE, 16'sd1, 16'sd1, 16'sd2, 16'sd2);
    send_command(FUNC_LINE, pick_coord(), pick_coord(), C_MAX, -16'sd3);

    // Smallest non-zero scale; step count above the limit clamps
    drain();
    configure(24'd1, 24'd127, 24'd1);
    send_command(FUNC_CURVE, -16'sd1, -16'sd1, 16'sd1, -16'sd1);

    // Measure mode, with junk in the unused register bits
    drain();
    configure(SCALE_RESET + 24'h123, 24'hFFFFC1, 24'hFFFFFE);
    send_command(FUNC_CURVE, pick_coord(), pick_coord(), pick_coord(), C_MAX);
    send_command(FUNC_LINE, pick_coord(), pick_coord(), pick_coord(), pick_coord());
    send_command(FUNC_MOVE, pick_coord(), pick_coord(), pick_coord(), pick_coord());
    send_command(FUNC_UNUSED, pick_coord(), pick_coord(), pick_coord(), pick_coord());

    // Back to segments, one chord per curve
    drain();
    configure(SCALE_RESET, 24'd1, 24'd1);
    send_command(FUNC_CURVE, pick_coord(), pick_coord(), pick_coord(), pick_coord());
    send_command(FUNC_LINE, pick_coord(), pick_coord(), pick_coord(), pick_coord());

    // Random phases: fresh settings each time, commands sent in bursts
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain();
      case ($urandom_range(0, 5))
        0:       scale_w = SCALE_RESET;
        1:       scale_w = '1;
        2:       scale_w = 24'($urandom_range(0, 255));
        3:       scale_w = 24'($urandom);
        4:       scale_w = 24'($urandom_range(1 << 15, 1 << 17));
        default: scale_w = '0;
      endcase
      // mostly short curves; now and then long ones, some past the step limit
      case ($urandom_range(0, 19))
        0, 1, 2: steps_val = $urandom_range(9, 20);
        3, 4:    steps_val = $urandom_range(56, 127);
        default: steps_val = $urandom_range(0, 8);
      endcase
      steps_w = {($urandom_range(0, 1) != 0) ? 17'($urandom) : 17'd0, 7'(steps_val)};
      emit_w  = {($urandom_range(0, 1) != 0) ? 23'($urandom) : 23'd0,
                 ($urandom_range(0, 4) != 0)};
      configure(scale_w, steps_w, emit_w);

      burst_left = 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 16);
          if ($urandom_range(0, 2) != 0) pause_input($urandom_range(1, 10));
        end
        send_command(pick_func(), pick_coord(), pick_coord(), pick_coord(), pick_coord());
        burst_left--;
      end
    end

    drain();
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/bzf_pkg.sv
rtl/core/bzf_lane.sv
rtl/core/bzf_datapath.sv
rtl/core/bzf_ctrl.sv
rtl/core/quadratic_bezier_flattener.sv
tb/sv/quadratic_bezier_flattener_tb.sv
